// File: hw/rtl/fte_pkg.sv
// Shared types and constants for the flow tuple header extractor.
// Used by fte_parse, fte_format, fte_outbuf and the top level; has no dependencies of its own.

package fte_pkg;

  // Frame geometry
  localparam int unsigned MAX_FRAME_BYTES = 16384;
  localparam int unsigned POS_W           = 16;
  localparam logic [POS_W-1:0] MAX_POS    = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] MIN_FRAME  = POS_W'(34);

  // Fixed header offsets
  localparam logic [POS_W-1:0] DMAC_END   = POS_W'(6);
  localparam logic [POS_W-1:0] SMAC_END   = POS_W'(12);
  localparam logic [POS_W-1:0] FIRST_TAG  = POS_W'(15);
  localparam logic [POS_W-1:0] IP_PROTO   = POS_W'(9);
  localparam logic [POS_W-1:0] IP_ADDR_LO = POS_W'(12);
  localparam logic [POS_W-1:0] IP_ADDR_HI = POS_W'(20);
  localparam logic [POS_W:0]   IP_HDR_MIN = (POS_W+1)'(20);
  localparam logic [POS_W:0]   L4_PORTS   = (POS_W+1)'(4);
  localparam logic [POS_W:0]   L4_ICMP    = (POS_W+1)'(2);

  // Field codes
  localparam logic [7:0]  TAG_MARK   = 8'h81;
  localparam logic [15:0] ETH_ARP    = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_ARP         = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_e;

  // Everything known about a frame once its last word is taken
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic             l3_found;
    logic [POS_W-1:0] l3_start;
    logic [POS_W-1:0] l4_start;
    logic [11:0]      vid;
    logic [31:0]      tag;
    logic             rev;
    logic             cpy;
    logic [47:0]      dmac;
    logic [47:0]      smac;
    logic [63:0]      ip;
    logic [7:0]       proto;
    logic [31:0]      l4_bytes;
  } frame_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] vlan_id;
    logic [15:0] ether_type;
    logic        mac_valid;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
  } result_t;

endpackage

// File: hw/rtl/fte_parse.sv
// Input register and per-frame parse state: byte counter, tag scan, field capture.
// Depends on fte_pkg.

module fte_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_frame_i,
  input  logic            reverse_dir_i,
  input  logic            copy_mac_i,
  input  logic            advance_i,
  output fte_pkg::frame_t frame_o,
  output logic            done_o
);

  localparam int unsigned PW = fte_pkg::POS_W;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  byte_q;
  logic        eof_q, rev_in_q, cpy_in_q;
  logic        step;

  logic [PW-1:0] cnt_q, cnt_d;
  logic [31:0]   tag_q, tag_d;
  logic          l3_found_q, l3_found_d;
  logic [PW-1:0] l3_q, l3_d;
  logic [PW-1:0] l4_q, l4_d;
  logic [11:0]   vid_q, vid_d;
  logic          rev_q, rev_d, cpy_q, cpy_d;
  logic [47:0]   dmac_q, dmac_d, smac_q, smac_d;
  logic [63:0]   ip_q, ip_d;
  logic [7:0]    proto_q, proto_d;
  logic [31:0]   l4b_q, l4b_d;

  // Hold the input word; take a new one whenever the pipe advances
  assign in_vld_d = (in_valid_i && advance_i) ? 1'b1 : (advance_i ? 1'b0 : in_vld_q);
  assign step     = in_vld_q && advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && advance_i) begin
      byte_q   <= data_byte_i;
      eof_q    <= end_of_frame_i;
      rev_in_q <= reverse_dir_i;
      cpy_in_q <= copy_mac_i;
    end
  end

  // Advance the frame state by one byte
  always_comb begin
    logic [PW-1:0] pos;
    logic [PW:0]   l4_sum;
    logic [PW-1:0] l3_off;
    logic [PW-1:0] ip_rel;
    logic [PW:0]   l4_off;
    pos        = cnt_q;
    l4_sum     = '0;
    l3_off     = pos - l3_q;
    ip_rel     = l3_off - fte_pkg::IP_ADDR_LO;
    l4_off     = {1'b0, pos} - {1'b0, l4_q};
    cnt_d      = cnt_q;
    tag_d      = tag_q;
    l3_found_d = l3_found_q;
    l3_d       = l3_q;
    l4_d       = l4_q;
    vid_d      = vid_q;
    rev_d      = rev_q;
    cpy_d      = cpy_q;
    dmac_d     = dmac_q;
    smac_d     = smac_q;
    ip_d       = ip_q;
    proto_d    = proto_q;
    l4b_d      = l4b_q;
    if (pos < fte_pkg::MAX_POS) begin
      cnt_d = pos + 1'b1;
      if (pos == '0) begin
        rev_d = rev_in_q;
        cpy_d = cpy_in_q;
      end
      if (pos < fte_pkg::DMAC_END) begin
        dmac_d = {dmac_q[39:0], byte_q};
      end else if (pos < fte_pkg::SMAC_END) begin
        smac_d = {smac_q[39:0], byte_q};
      end else if (!l3_found_q) begin
        // Scan tags four bytes at a time until the type is not a tag
        tag_d = {tag_q[23:0], byte_q};
        if (pos >= fte_pkg::FIRST_TAG && pos[1:0] == 2'b11) begin
          if (tag_d[31:24] == fte_pkg::TAG_MARK) begin
            if (pos == fte_pkg::FIRST_TAG) begin
              vid_d = tag_d[11:0];
            end
          end else begin
            l3_found_d = 1'b1;
            l3_d       = pos - 1'b1;
            l4_sum     = {1'b0, l3_d} + {{(PW-5){1'b0}}, tag_d[11:8], 2'b00};
            l4_d       = l4_sum[PW] ? {PW{1'b1}} : l4_sum[PW-1:0];
            // Zero header length puts the L4 header on the first two IP bytes
            if (tag_d[11:8] == 4'd0) begin
              l4b_d[31:24] = tag_d[15:8];
              l4b_d[23:16] = byte_q;
            end
          end
        end
      end
      // Capture address, protocol and L4 bytes once the IP header is located
      if (l3_found_q) begin
        if (l3_off >= fte_pkg::IP_ADDR_LO && l3_off < fte_pkg::IP_ADDR_HI) begin
          ip_d[{~ip_rel[2:0], 3'b000} +: 8] = byte_q;
        end
        if (l3_off == fte_pkg::IP_PROTO) begin
          proto_d = byte_q;
        end
        if (!l4_off[PW] && l4_off[PW-1:2] == '0) begin
          l4b_d[{~l4_off[1:0], 3'b000} +: 8] = byte_q;
        end
      end
    end
  end

  // Update on each byte; drop all frame state after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      tag_q      <= '0;
      l3_found_q <= 1'b0;
      l3_q       <= '0;
      l4_q       <= '0;
      vid_q      <= '0;
      rev_q      <= 1'b0;
      cpy_q      <= 1'b0;
      dmac_q     <= '0;
      smac_q     <= '0;
      ip_q       <= '0;
      proto_q    <= '0;
      l4b_q      <= '0;
    end else if (step) begin
      if (eof_q) begin
        cnt_q      <= '0;
        tag_q      <= '0;
        l3_found_q <= 1'b0;
        l3_q       <= '0;
        l4_q       <= '0;
        vid_q      <= '0;
        rev_q      <= 1'b0;
        cpy_q      <= 1'b0;
        dmac_q     <= '0;
        smac_q     <= '0;
        ip_q       <= '0;
        proto_q    <= '0;
        l4b_q      <= '0;
      end else begin
        cnt_q      <= cnt_d;
        tag_q      <= tag_d;
        l3_found_q <= l3_found_d;
        l3_q       <= l3_d;
        l4_q       <= l4_d;
        vid_q      <= vid_d;
        rev_q      <= rev_d;
        cpy_q      <= cpy_d;
        dmac_q     <= dmac_d;
        smac_q     <= smac_d;
        ip_q       <= ip_d;
        proto_q    <= proto_d;
        l4b_q      <= l4b_d;
      end
    end
  end

  // Present the frame as it stands after this byte
  always_comb begin
    frame_o.len      = cnt_d;
    frame_o.l3_found = l3_found_d;
    frame_o.l3_start = l3_d;
    frame_o.l4_start = l4_d;
    frame_o.vid      = vid_d;
    frame_o.tag      = tag_d;
    frame_o.rev      = rev_d;
    frame_o.cpy      = cpy_d;
    frame_o.dmac     = dmac_d;
    frame_o.smac     = smac_d;
    frame_o.ip       = ip_d;
    frame_o.proto    = proto_d;
    frame_o.l4_bytes = l4b_d;
  end

  assign done_o = step && eof_q;

endmodule

// File: hw/rtl/fte_format.sv
// Result formatting: status decision, direction swap and field selection.
// Depends on fte_pkg.

module fte_format (
  input  fte_pkg::frame_t  frame_i,
  output fte_pkg::result_t res_o
);

  localparam int unsigned PW = fte_pkg::POS_W;

  logic [PW:0] len_x, l3_x, l4_x;
  logic [31:0] ip_a, ip_b;
  logic [15:0] l4_s, l4_d;

  assign len_x = {1'b0, frame_i.len};
  assign l3_x  = {1'b0, frame_i.l3_start};
  assign l4_x  = {1'b0, frame_i.l4_start};
  assign ip_a  = frame_i.ip[63:32];
  assign ip_b  = frame_i.ip[31:0];
  assign l4_s  = frame_i.l4_bytes[31:16];
  assign l4_d  = frame_i.l4_bytes[15:0];

  // Decide status and select the fields it allows
  always_comb begin
    res_o = '0;
    if (frame_i.len < fte_pkg::MIN_FRAME) begin
      res_o.status = fte_pkg::ST_SHORT;
    end else if (!frame_i.l3_found) begin
      res_o.status  = fte_pkg::ST_TRUNCATED;
      res_o.vlan_id = frame_i.vid;
    end else begin
      res_o.vlan_id    = frame_i.vid;
      res_o.ether_type = frame_i.tag[31:16];
      if (frame_i.tag[31:16] == fte_pkg::ETH_ARP) begin
        res_o.status = fte_pkg::ST_ARP;
      end else begin
        // Frames with a nonzero first VID keep their MACs only on request
        if (frame_i.cpy || frame_i.vid == '0) begin
          res_o.mac_valid = 1'b1;
          res_o.dst_mac   = frame_i.rev ? frame_i.smac : frame_i.dmac;
          res_o.src_mac   = frame_i.rev ? frame_i.dmac : frame_i.smac;
        end
        if (l3_x + fte_pkg::IP_HDR_MIN > len_x) begin
          res_o.status = fte_pkg::ST_TRUNCATED;
        end else if (frame_i.proto == fte_pkg::PROTO_TCP ||
                     frame_i.proto == fte_pkg::PROTO_UDP) begin
          if (l4_x + fte_pkg::L4_PORTS > len_x) begin
            res_o.status = fte_pkg::ST_TRUNCATED;
          end else begin
            res_o.src_ip      = frame_i.rev ? ip_b : ip_a;
            res_o.dst_ip      = frame_i.rev ? ip_a : ip_b;
            res_o.ip_protocol = frame_i.proto;
            res_o.l4_src      = frame_i.rev ? l4_d : l4_s;
            res_o.l4_dst      = frame_i.rev ? l4_s : l4_d;
          end
        end else if (frame_i.proto == fte_pkg::PROTO_ICMP) begin
          // ICMP type and code keep their places in either direction
          if (l4_x + fte_pkg::L4_ICMP > len_x) begin
            res_o.status = fte_pkg::ST_TRUNCATED;
          end else begin
            res_o.src_ip      = frame_i.rev ? ip_b : ip_a;
            res_o.dst_ip      = frame_i.rev ? ip_a : ip_b;
            res_o.ip_protocol = frame_i.proto;
            res_o.l4_src      = {8'd0, frame_i.l4_bytes[31:24]};
            res_o.l4_dst      = {8'd0, frame_i.l4_bytes[23:16]};
          end
        end else begin
          res_o.status      = fte_pkg::ST_UNSUPPORTED;
          res_o.src_ip      = frame_i.rev ? ip_b : ip_a;
          res_o.dst_ip      = frame_i.rev ? ip_a : ip_b;
          res_o.ip_protocol = frame_i.proto;
        end
      end
    end
  end

endmodule

// File: hw/rtl/fte_outbuf.sv
// Result register with a one-entry skid stage toward the output channel.
// Depends on fte_pkg.

module fte_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fte_pkg::result_t res_i,
  input  logic             push_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output fte_pkg::result_t res_o,
  output logic             skid_full_o
);

  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;
  fte_pkg::result_t out_q, out_d;
  fte_pkg::result_t skid_q, skid_d;
  logic             take;

  assign take = out_vld_q && !out_stall_i;

  // Refill the output word from the skid stage first, then from the parser
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || take) begin
        out_d     = res_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign skid_full_o = skid_vld_q;

endmodule

// File: hw/rtl/flow_tuple_header_extractor_top.sv
// Timing: the last byte accepted is held in the input register, and its result word
// is registered from there into the output word; a full skid stage holds it back.
// Throughput: one byte word per cycle while the skid stage is empty, set by the input
// register and the parse step; a two-entry output buffer takes results under stall.
// Reset (rst_ni low, asynchronous) empties both buffers and clears frame state.
// Top level of the flow tuple header extractor; depends on fte_pkg, fte_parse,
// fte_format and fte_outbuf.

module flow_tuple_header_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  input  logic        reverse_dir_i,
  input  logic        copy_mac_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [11:0] vlan_id_o,
  output logic [15:0] ether_type_o,
  output logic        mac_valid_o,
  output logic [47:0] dst_mac_o,
  output logic [47:0] src_mac_o,
  output logic [31:0] src_ip_o,
  output logic [31:0] dst_ip_o,
  output logic [7:0]  ip_protocol_o,
  output logic [15:0] l4_src_o,
  output logic [15:0] l4_dst_o
);

  fte_pkg::frame_t  frame;
  fte_pkg::result_t res_new;
  fte_pkg::result_t res_out;
  logic             done;
  logic             skid_full;

  fte_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .reverse_dir_i  (reverse_dir_i),
    .copy_mac_i     (copy_mac_i),
    .advance_i      (!skid_full),
    .frame_o        (frame),
    .done_o         (done)
  );

  fte_format u_format (
    .frame_i (frame),
    .res_o   (res_new)
  );

  fte_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_new),
    .push_i      (done),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .skid_full_o (skid_full)
  );

  // Hold input while the skid stage is occupied
  assign in_stall_o = skid_full;

  assign status_o      = res_out.status;
  assign vlan_id_o     = res_out.vlan_id;
  assign ether_type_o  = res_out.ether_type;
  assign mac_valid_o   = res_out.mac_valid;
  assign dst_mac_o     = res_out.dst_mac;
  assign src_mac_o     = res_out.src_mac;
  assign src_ip_o      = res_out.src_ip;
  assign dst_ip_o      = res_out.dst_ip;
  assign ip_protocol_o = res_out.ip_protocol;
  assign l4_src_o      = res_out.l4_src;
  assign l4_dst_o      = res_out.l4_dst;

endmodule

// File: hw/rtl/fte_checker.sv
// Port-level checks for the flow tuple header extractor, bound to its top level.
// Depends on flow_tuple_header_extractor_top port names only.

module fte_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic end_of_frame_i,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A stalled result word stays on the channel
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Input stall only while a result word is waiting
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Input stall begins only after the output was stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output backpressure");

  // A result word appears only after an accepted last byte
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && end_of_frame_i, 2))
    else $error("result word without a frame end");

endmodule

bind flow_tuple_header_extractor_top fte_checker u_fte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .end_of_frame_i (end_of_frame_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i)
);

// File: test/flow_tuple_header_extractor_top_tb.sv
// Self-checking testbench for flow_tuple_header_extractor_top: drives frames byte by
// byte and checks every extracted tuple against an in-bench frame parser.
// Depends on fte_pkg and the RTL of the block.

module flow_tuple_header_extractor_top_tb;
  import fte_pkg::*;

  localparam logic [15:0] ETH_IPV4       = 16'h0800;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned RANDOM_BYTES   = 200;
  localparam int unsigned RANDOM_FRAMES  = 4;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        end_of_frame_i = 1'b0;
  logic        reverse_dir_i  = 1'b0;
  logic        copy_mac_i     = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  status_o;
  logic [11:0] vlan_id_o;
  logic [15:0] ether_type_o;
  logic        mac_valid_o;
  logic [47:0] dst_mac_o;
  logic [47:0] src_mac_o;
  logic [31:0] src_ip_o;
  logic [31:0] dst_ip_o;
  logic [7:0]  ip_protocol_o;
  logic [15:0] l4_src_o;
  logic [15:0] l4_dst_o;

  flow_tuple_header_extractor_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .reverse_dir_i  (reverse_dir_i),
    .copy_mac_i     (copy_mac_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .vlan_id_o      (vlan_id_o),
    .ether_type_o   (ether_type_o),
    .mac_valid_o    (mac_valid_o),
    .dst_mac_o      (dst_mac_o),
    .src_mac_o      (src_mac_o),
    .src_ip_o       (src_ip_o),
    .dst_ip_o       (dst_ip_o),
    .ip_protocol_o  (ip_protocol_o),
    .l4_src_o       (l4_src_o),
    .l4_dst_o       (l4_dst_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shared run control
  logic        idling     = 1'b1;
  logic        hold_req   = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  frame_bytes[$];
  result_t     expected_tuples[$];
  result_t     oldest_tuple;

  // Parser state for the frame in flight
  int unsigned frame_pos;
  int unsigned ip_hdr_off;
  int unsigned l4_hdr_off;
  logic [31:0] type_window;
  logic [11:0] first_vid;
  logic        swap_dir;
  logic        keep_mac;
  logic [47:0] dmac_sr;
  logic [47:0] smac_sr;
  logic [63:0] ip_addr_bytes;
  logic [39:0] proto_ports;

  task automatic clear_frame_state();
    frame_pos     = 0;
    ip_hdr_off    = 0;
    l4_hdr_off    = 0;
    type_window   = '0;
    first_vid     = '0;
    swap_dir      = 1'b0;
    keep_mac      = 1'b0;
    dmac_sr       = '0;
    smac_sr       = '0;
    ip_addr_bytes = '0;
    proto_ports   = '0;
  endtask

  // Latch address, protocol and L4 bytes once the IPv4 header offset is known
  task automatic latch_header_byte(int unsigned pos, logic [7:0] b);
    int unsigned base;
    base = ip_hdr_off;
    if (base == 0) return;
    if (pos >= base + 12 && pos < base + 20)
      ip_addr_bytes |= 64'(b) << ((7 - (pos - base - 12)) * 8);
    if (pos == base + 9)
      proto_ports[39:32] |= b;
    if (pos >= l4_hdr_off && pos < l4_hdr_off + 4)
      proto_ports |= 40'(b) << ((3 - (pos - l4_hdr_off)) * 8);
  endtask

  // Advance the parser by one accepted word; queue the tuple on the last one
  task automatic parse_frame_byte(logic [7:0] b, logic eof, logic rev, logic cpy);
    int unsigned pos;
    int unsigned l4;
    int unsigned len;
    result_t     r;
    pos = frame_pos;
    if (pos < MAX_FRAME_BYTES) begin
      if (pos == 0) begin
        swap_dir = rev;
        keep_mac = cpy;
      end
      if (pos < 6) begin
        dmac_sr = {dmac_sr[39:0], b};
      end else if (pos < 12) begin
        smac_sr = {smac_sr[39:0], b};
      end else if (ip_hdr_off == 0) begin
        type_window = {type_window[23:0], b};
        if (pos >= 15 && pos % 4 == 3) begin
          if (type_window[31:24] == TAG_MARK) begin
            if (pos == 15) first_vid = type_window[11:0];
          end else begin
            ip_hdr_off = pos - 1;
            l4 = ip_hdr_off + 4 * type_window[11:8];
            l4_hdr_off = (l4 > 32'hFFFF) ? 32'hFFFF : l4;
            latch_header_byte(pos - 1, type_window[15:8]);
          end
        end
      end
      latch_header_byte(pos, b);
      frame_pos = pos + 1;
    end
    if (!eof) return;

    len = frame_pos;
    r   = '0;
    if (len < 34) begin
      r.status = ST_SHORT;
    end else if (ip_hdr_off == 0) begin
      r.status  = ST_TRUNCATED;
      r.vlan_id = first_vid;
    end else begin
      r.vlan_id    = first_vid;
      r.ether_type = type_window[31:16];
      if (r.ether_type == ETH_ARP) begin
        r.status = ST_ARP;
      end else begin
        // MACs go out unless a nonzero first VID hides them and no copy was requested
        if (keep_mac || first_vid == 0) begin
          r.mac_valid = 1'b1;
          r.dst_mac   = swap_dir ? smac_sr : dmac_sr;
          r.src_mac   = swap_dir ? dmac_sr : smac_sr;
        end
        if (ip_hdr_off + 20 > len) begin
          r.status = ST_TRUNCATED;
        end else begin
          r.src_ip      = swap_dir ? ip_addr_bytes[31:0] : ip_addr_bytes[63:32];
          r.dst_ip      = swap_dir ? ip_addr_bytes[63:32] : ip_addr_bytes[31:0];
          r.ip_protocol = proto_ports[39:32];
          if (r.ip_protocol == PROTO_TCP || r.ip_protocol == PROTO_UDP) begin
            if (l4_hdr_off + 4 > len) begin
              r.status      = ST_TRUNCATED;
              r.src_ip      = '0;
              r.dst_ip      = '0;
              r.ip_protocol = '0;
            end else begin
              r.l4_src = swap_dir ? proto_ports[15:0] : proto_ports[31:16];
              r.l4_dst = swap_dir ? proto_ports[31:16] : proto_ports[15:0];
            end
          end else if (r.ip_protocol == PROTO_ICMP) begin
            // ICMP type and code never swap
            if (l4_hdr_off + 2 > len) begin
              r.status      = ST_TRUNCATED;
              r.src_ip      = '0;
              r.dst_ip      = '0;
              r.ip_protocol = '0;
            end else begin
              r.l4_src = {8'h00, proto_ports[31:24]};
              r.l4_dst = {8'h00, proto_ports[23:16]};
            end
          end else begin
            r.status = ST_UNSUPPORTED;
          end
        end
      end
    end
    expected_tuples.push_back(r);
    clear_frame_state();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track accepted words on both channels and compare each result word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      parse_frame_byte(data_byte_i, end_of_frame_i, reverse_dir_i, copy_mac_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tuples.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual status %0d",
                 $time, status_o);
        mismatches++;
      end else begin
        oldest_tuple = expected_tuples.pop_front();
        check_field("status",      oldest_tuple.status,      status_o);
        check_field("vlan_id",     oldest_tuple.vlan_id,     vlan_id_o);
        check_field("ether_type",  oldest_tuple.ether_type,  ether_type_o);
        check_field("mac_valid",   oldest_tuple.mac_valid,   mac_valid_o);
        check_field("dst_mac",     oldest_tuple.dst_mac,     dst_mac_o);
        check_field("src_mac",     oldest_tuple.src_mac,     src_mac_o);
        check_field("src_ip",      oldest_tuple.src_ip,      src_ip_o);
        check_field("dst_ip",      oldest_tuple.dst_ip,      dst_ip_o);
        check_field("ip_protocol", oldest_tuple.ip_protocol, ip_protocol_o);
        check_field("l4_src",      oldest_tuple.l4_src,      l4_src_o);
        check_field("l4_dst",      oldest_tuple.l4_dst,      l4_dst_o);
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Hang detection: end the run when no word moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one word, with an optional gap ahead of it; hold until accepted
  task automatic offer_byte(logic [7:0] b, logic eof, logic rev, logic cpy);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_frame_i <= eof;
    reverse_dir_i  <= rev;
    copy_mac_i     <= cpy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic put_byte(int unsigned idx, logic [7:0] val);
    if (idx < frame_bytes.size()) frame_bytes[idx] = val;
  endtask

  // Build a frame of random bytes with the given tags and headers, then send it
  task automatic send_frame(int unsigned n_tags, logic [11:0] vid, logic [15:0] etype,
                            logic [3:0] ihl, logic [7:0] proto, int unsigned len,
                            logic rev, logic cpy);
    int unsigned i;
    int unsigned l3;
    frame_bytes.delete();
    for (i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    for (i = 0; i < n_tags; i++) begin
      put_byte(12 + 4 * i, TAG_MARK);
      put_byte(13 + 4 * i, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      put_byte(14 + 4 * i, {4'($urandom), (i == 0) ? vid[11:8] : 4'($urandom)});
      put_byte(15 + 4 * i, (i == 0) ? vid[7:0] : 8'($urandom));
    end
    l3 = 14 + 4 * n_tags;
    put_byte(l3 - 2, etype[15:8]);
    put_byte(l3 - 1, etype[7:0]);
    put_byte(l3, {4'h4, ihl});
    put_byte(l3 + 9, proto);
    for (i = 0; i < frame_bytes.size(); i++)
      offer_byte(frame_bytes[i], i == frame_bytes.size() - 1,
                 (i == 0) ? rev : 1'($urandom), (i == 0) ? cpy : 1'($urandom));
  endtask

  task automatic test_short_frames();
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_TCP, 1, 1'b0, 1'b0);
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_TCP, 33, 1'b1, 1'b1);
    // minimum length: IPv4 header fits, TCP ports do not
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_TCP, 34, 1'b0, 1'b0);
  endtask

  task automatic test_l4_protocols();
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_TCP, 54, 1'b0, 1'b0);
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_TCP, 60, 1'b1, 1'b0);
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_UDP, 42, 1'b1, 1'b1);
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_ICMP, 36, 1'b0, 1'b0);
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_ICMP, 36, 1'b1, 1'b0);
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_ICMP, 35, 1'b1, 1'b1);
  endtask

  task automatic test_vlan_tags();
    send_frame(1, 12'h123, ETH_IPV4, 4'd5, PROTO_UDP, 60, 1'b0, 1'b0);
    send_frame(1, 12'hFFF, ETH_IPV4, 4'd5, PROTO_TCP, 60, 1'b1, 1'b1);
    // a zero VID still counts as untagged for the MACs
    send_frame(1, 12'h000, ETH_IPV4, 4'd5, PROTO_TCP, 60, 1'b1, 1'b0);
    send_frame(3, 12'h00A, ETH_IPV4, 4'd5, PROTO_ICMP, 70, 1'b0, 1'b0);
  endtask

  task automatic test_arp_and_other_types();
    send_frame(0, 12'h000, ETH_ARP, 4'd5, PROTO_TCP, 42, 1'b0, 1'b0);
    send_frame(1, 12'h055, ETH_ARP, 4'd5, PROTO_UDP, 64, 1'b1, 1'b1);
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, 8'h00, 40, 1'b0, 1'b0);
    send_frame(0, 12'h000, 16'hFFFF, 4'd5, 8'hFF, 60, 1'b1, 1'b1);
    send_frame(0, 12'h000, 16'h0000, 4'd5, PROTO_UDP, 60, 1'b0, 1'b1);
  endtask

  task automatic test_truncation();
    // tags all the way to the end, then a type word cut short
    send_frame(7, 12'h321, ETH_IPV4, 4'd5, PROTO_TCP, 40, 1'b0, 1'b0);
    send_frame(5, 12'h001, ETH_IPV4, 4'd5, PROTO_TCP, 35, 1'b1, 1'b0);
    // IPv4 addresses past the frame end
    send_frame(2, 12'h007, ETH_IPV4, 4'd5, PROTO_TCP, 40, 1'b1, 1'b1);
    // zero IHL puts L4 at the IPv4 header itself
    send_frame(0, 12'h000, ETH_IPV4, 4'd0, PROTO_TCP, 40, 1'b0, 1'b0);
    send_frame(0, 12'h000, ETH_IPV4, 4'd15, PROTO_TCP, 78, 1'b1, 1'b0);
    send_frame(0, 12'h000, ETH_IPV4, 4'd15, PROTO_UDP, 77, 1'b0, 1'b1);
  endtask

  // Hold the result side while short frames keep coming, so the block backs up
  task automatic test_output_backpressure();
    int unsigned n;
    idling   = 1'b0;
    hold_req = 1'b1;
    for (n = 0; n < 24; n++)
      send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_TCP, $urandom_range(1, 3),
                 1'($urandom), 1'($urandom));
    send_frame(0, 12'h000, ETH_IPV4, 4'd5, PROTO_UDP, 50, 1'b1, 1'b0);
    idling = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned sent_bytes;
    int unsigned frames;
    int unsigned kind;
    int unsigned nt;
    int unsigned l3;
    int unsigned l4;
    int unsigned len;
    logic [11:0] vid;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    sent_bytes = 0;
    frames     = 0;
    while (sent_bytes < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
      idling = ($urandom_range(0, 3) != 0);
      kind   = $urandom_range(0, 9);
      nt     = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      vid    = ($urandom_range(0, 3) == 0) ? 12'h000 : 12'($urandom);
      ihl    = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
      case ($urandom_range(0, 3))
        0:       proto = PROTO_TCP;
        1:       proto = PROTO_UDP;
        2:       proto = PROTO_ICMP;
        default: proto = 8'($urandom);
      endcase
      etype = ($urandom_range(0, 5) == 0) ? {8'($urandom_range(0, 8'h80)), 8'($urandom)}
                                           : ETH_IPV4;
      l3  = 14 + 4 * nt;
      l4  = l3 + 4 * ihl;
      len = ((l4 + 4 > l3 + 20) ? l4 + 4 : l3 + 20) + $urandom_range(0, 24);
      if (kind == 7) begin
        etype = ETH_ARP;
      end else if (kind == 8) begin
        // noise: arbitrary structure and length
        etype = 16'($urandom);
        ihl   = 4'($urandom);
        proto = 8'($urandom);
        len   = $urandom_range(1, 80);
      end else if (kind == 9) begin
        len = $urandom_range(30, l4 + 3);
      end
      send_frame(nt, vid, etype, ihl, proto, len, 1'($urandom), 1'($urandom));
      sent_bytes += len;
      frames++;
    end
  endtask

  // Close with back-to-back traffic and no idling on either side
  task automatic test_back_to_back();
    int unsigned n;
    idling = 1'b0;
    for (n = 0; n < 3; n++)
      send_frame(n % 2, 12'($urandom), ETH_IPV4, 4'd5, PROTO_TCP, $urandom_range(54, 70),
                 1'($urandom), 1'($urandom));
  endtask

  initial begin
    clear_frame_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_short_frames();
    test_l4_protocols();
    test_vlan_tags();
    test_arp_and_other_types();
    test_truncation();
    test_output_backpressure();
    test_random_traffic();
    test_back_to_back();

    // Drain: wait for every tuple, then keep watching for anything stray
    in_valid_i <= 1'b0;
    while (expected_tuples.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fte_pkg.sv
hw/rtl/fte_parse.sv
hw/rtl/fte_format.sv
hw/rtl/fte_outbuf.sv
hw/rtl/flow_tuple_header_extractor_top.sv
hw/rtl/fte_checker.sv
test/flow_tuple_header_extractor_top_tb.sv
